// ===== design/maaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alert admission filter package
// Shared constants, codes and types for the admission filter and its cells.
// ----------------------------------------------------------------------------
package maaf_pkg;

   // Nonce history depth (one cell per entry)
   localparam int NONCE_DEPTH = 32;
   localparam int NONCE_W     = 64;

   // Freshness and rate window limits
   localparam logic [31:0] FUTURE_SLACK_S = 32'd30;
   localparam logic [31:0] MAX_AGE_S      = 32'd300;
   localparam logic [31:0] WINDOW_MS      = 32'd60000;

   // now_ms / 1000 as (now_ms * RECIP_1000) >> RECIP_SHIFT, exact for 32-bit inputs
   localparam int          RECIP_W     = 29;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;
   localparam int          PROD_W      = 32 + RECIP_W;
   localparam int          SEC_W       = PROD_W - RECIP_SHIFT;

   typedef enum logic [2:0] {
      VERDICT_SHORT   = 3'd0,
      VERDICT_DUP     = 3'd1,
      VERDICT_STALE   = 3'd2,
      VERDICT_URGENCY = 3'd3,
      VERDICT_MUTED   = 3'd4,
      VERDICT_OWN     = 3'd5,
      VERDICT_ACCEPT  = 3'd6
   } verdict_type;

   typedef enum logic [2:0] {
      CSR_MIN_FRAME_LEN  = 3'd0,
      CSR_URGENCY_MIN    = 3'd1,
      CSR_MUTE_ACTIVE    = 3'd2,
      CSR_MUTE_UNTIL_MS  = 3'd3,
      CSR_OWN_SESSION_ID = 3'd4,
      CSR_RELAY_ENABLED  = 3'd5,
      CSR_MAX_HOPS       = 3'd6,
      CSR_RELAY_LIMIT    = 3'd7
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_DECIDE
   } state_type;

   // Control handed from the sequencer to the nonce cell row
   typedef struct packed {
      logic lookup;   // capture compare result against the incoming nonce
      logic insert;   // shift the row by one and take the new nonce at the head
   } chain_ctl_type;

endpackage

// ===== design/maaf_nonce_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nonce history cell
// Holds one remembered nonce, compares it to a lookup key, and passes its
// entry to the next cell when the row shifts.
// ----------------------------------------------------------------------------
module maaf_nonce_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  maaf_pkg::chain_ctl_type ctl,
   input  logic [maaf_pkg::NONCE_W-1:0] key,
   input  logic [maaf_pkg::NONCE_W-1:0] shift_in,
   output logic [maaf_pkg::NONCE_W-1:0] entry,
   output logic                   hit
);
   import maaf_pkg::*;

   logic [NONCE_W-1:0] entry_ff, entry_in;
   logic               hit_ff, hit_in;

   always_comb begin
      entry_in = ctl.insert ? shift_in : entry_ff;
      hit_in   = ctl.lookup ? (entry_ff == key) : hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         hit_ff   <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== design/maaf_nonce_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nonce history row
// A row of history cells; insertion shifts every entry one cell down and
// drops the oldest off the end. Reports whether any cell matched.
// ----------------------------------------------------------------------------
module maaf_nonce_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  maaf_pkg::chain_ctl_type ctl,
   input  logic [maaf_pkg::NONCE_W-1:0] key,
   input  logic [maaf_pkg::NONCE_W-1:0] ins_nonce,
   output logic                   dup
);
   import maaf_pkg::*;

   logic [NONCE_W-1:0]     entry_vec [NONCE_DEPTH];
   logic [NONCE_W-1:0]     feed_vec  [NONCE_DEPTH];
   logic [NONCE_DEPTH-1:0] hit_vec;

   // head takes the new nonce, every other cell takes its upstream neighbor
   assign feed_vec[0] = ins_nonce;

   for (genvar i = 0; i < NONCE_DEPTH; i++) begin : g_cell
      if (i > 0) begin : g_feed
         assign feed_vec[i] = entry_vec[i-1];
      end
      maaf_nonce_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .key      (key),
         .shift_in (feed_vec[i]),
         .entry    (entry_vec[i]),
         .hit      (hit_vec[i])
      );
   end

   assign dup = |hit_vec;

endmodule

// ===== design/mesh_alert_admission_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh alert admission filter
// Checks alert frame headers for length, replay, freshness, urgency, mute and
// own origin, and decides on rate-limited relaying of accepted frames.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one beat carries one frame header plus the
//    current millisecond time. A beat is taken when req_valid is high and
//    req_stall is low.
//  - Response channel (rsp_*): one beat per request with the verdict and the
//    relay decision. The receiver holds rsp_stall high to stall; the beat
//    stays on the port unchanged until taken.
//  - Config port (csr_*): one register write per cycle with csr_write high;
//    the user must make writes only while idle; the block does not enforce it.
//  - Timing: the accepting edge runs the nonce compare in every history
//    cell and the reciprocal multiply for seconds; the decide step, once
//    the response register is free, forms the verdict, shifts a long-enough
//    non-replayed nonce into the history row and loads the response register.
//    A new request can be taken even while that response waits on a stalled
//    receiver; the next beat then holds in decide until the register frees.
//  - Reset: the history row clears to all-zero nonces (so a zero nonce reads
//    as a replay until the row has turned over), the relay window restarts at
//    time zero with no relays, and the config registers take their defaults.
// ----------------------------------------------------------------------------
module mesh_alert_admission_filter (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_length,
   input  logic [63:0] req_nonce,
   input  logic [63:0] req_sender_id,
   input  logic [31:0] req_sent_seconds,
   input  logic [7:0]  req_urgency,
   input  logic [7:0]  req_hops,
   input  logic [31:0] req_now_ms,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_verdict,
   output logic        rsp_relay,
   output logic [7:0]  rsp_relay_hops,
   output logic        rsp_rate_limited,
   // config port
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import maaf_pkg::*;

   // ---------------------------------------------------------------- config
   logic [7:0]  min_len_ff;
   logic [7:0]  urgency_min_ff;
   logic        mute_active_ff;
   logic [31:0] mute_until_ff;
   logic [63:0] own_id_ff;
   logic        relay_en_ff;
   logic [7:0]  max_hops_ff;
   logic [7:0]  relay_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff     <= 8'd16;
         urgency_min_ff <= 8'd0;
         mute_active_ff <= 1'b0;
         mute_until_ff  <= 32'd0;
         own_id_ff      <= 64'd0;
         relay_en_ff    <= 1'b1;
         max_hops_ff    <= 8'd3;
         relay_limit_ff <= 8'd10;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_FRAME_LEN:  min_len_ff     <= csr_data[7:0];
            CSR_URGENCY_MIN:    urgency_min_ff <= csr_data[7:0];
            CSR_MUTE_ACTIVE:    mute_active_ff <= csr_data[0];
            CSR_MUTE_UNTIL_MS:  mute_until_ff  <= csr_data[31:0];
            CSR_OWN_SESSION_ID: own_id_ff      <= csr_data;
            CSR_RELAY_ENABLED:  relay_en_ff    <= csr_data[0];
            CSR_MAX_HOPS:       max_hops_ff    <= csr_data[7:0];
            CSR_RELAY_LIMIT:    relay_limit_ff <= csr_data[7:0];
         endcase
      end
   end

   // ------------------------------------------------------------- sequencer
   state_type state_ff, state_in;
   logic      take;      // request beat accepted this cycle
   logic      finish;    // decide step completes, response register loads
   logic      out_free;

   assign out_free = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE: if (out_free)  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      take      = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            take      = req_valid;
         end
         ST_DECIDE: begin
            finish = out_free;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --------------------------------------------------- captured request beat
   logic [7:0]        len_ff;
   logic [63:0]       nonce_ff;
   logic [63:0]       sender_ff;
   logic [31:0]       sent_ff;
   logic [7:0]        urgency_ff;
   logic [7:0]        hops_ff;
   logic [31:0]       now_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // seconds come from a reciprocal multiply; the shift finishes in decide
   assign prod_in = PROD_W'(req_now_ms) * PROD_W'(RECIP_1000);

   always_ff @(posedge clock) begin
      if (take) begin
         len_ff     <= req_frame_length;
         nonce_ff   <= req_nonce;
         sender_ff  <= req_sender_id;
         sent_ff    <= req_sent_seconds;
         urgency_ff <= req_urgency;
         hops_ff    <= req_hops;
         now_ff     <= req_now_ms;
         prod_ff    <= prod_in;
      end
   end

   // ------------------------------------------------------ nonce history row
   chain_ctl_type chain_ctl;
   logic          dup;
   logic          short_frame;

   assign short_frame = len_ff < min_len_ff;

   // compare on the accepting edge; insert every long-enough nonce not already in the row
   always_comb begin
      chain_ctl.lookup = take;
      chain_ctl.insert = finish && !short_frame && !dup;
   end

   maaf_nonce_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (chain_ctl),
      .key       (req_nonce),
      .ins_nonce (nonce_ff),
      .dup       (dup)
   );

   // ---------------------------------------------------------------- verdict
   logic [31:0]  now_sec;
   logic [31:0]  age_sec;
   logic         stale;
   logic         muted;
   verdict_type  verdict;

   always_comb begin
      now_sec = 32'(prod_ff[PROD_W-1:RECIP_SHIFT]);
      age_sec = now_sec - sent_ff;
      // future check cannot wrap: now_sec stays far below 2^32 - 30
      stale   = (sent_ff > now_sec + FUTURE_SLACK_S) || (age_sec > MAX_AGE_S);
      muted   = mute_active_ff && (now_ff < mute_until_ff);

      if (short_frame) begin
         verdict = VERDICT_SHORT;
      end else if (dup) begin
         verdict = VERDICT_DUP;
      end else if (stale) begin
         verdict = VERDICT_STALE;
      end else if (urgency_ff < urgency_min_ff) begin
         verdict = VERDICT_URGENCY;
      end else if (muted) begin
         verdict = VERDICT_MUTED;
      end else if (sender_ff == own_id_ff) begin
         verdict = VERDICT_OWN;
      end else begin
         verdict = VERDICT_ACCEPT;
      end
   end

   // ---------------------------------------------------- relay rate limiter
   logic [31:0] win_start_ff, win_start_in;
   logic [7:0]  win_count_ff, win_count_in;
   logic [31:0] win_elapsed;
   logic        win_expired;
   logic [7:0]  count_eff;
   logic        want_relay;
   logic        limited;
   logic        relay;

   always_comb begin
      want_relay  = (verdict == VERDICT_ACCEPT) && relay_en_ff && (hops_ff < max_hops_ff);
      win_elapsed = now_ff - win_start_ff;
      win_expired = win_elapsed > WINDOW_MS;
      count_eff   = win_expired ? 8'd0 : win_count_ff;
      limited     = want_relay && (count_eff >= relay_limit_ff);
      relay       = want_relay && !limited;

      // leave the window alone when no relay is wanted
      win_start_in = win_start_ff;
      win_count_in = win_count_ff;
      if (finish && want_relay) begin
         if (win_expired) win_start_in = now_ff;
         win_count_in = relay ? count_eff + 8'd1 : count_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= 32'd0;
         win_count_ff <= 8'd0;
      end else begin
         win_start_ff <= win_start_in;
         win_count_ff <= win_count_in;
      end
   end

   // ------------------------------------------------------ response register
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_verdict_ff;
   logic        rsp_relay_ff;
   logic [7:0]  rsp_hops_ff;
   logic        rsp_limited_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_verdict_ff <= verdict;
         rsp_relay_ff   <= relay;
         rsp_hops_ff    <= relay ? hops_ff + 8'd1 : 8'd0;
         rsp_limited_ff <= limited;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_relay        = rsp_relay_ff;
   assign rsp_relay_hops   = rsp_hops_ff;
   assign rsp_rate_limited = rsp_limited_ff;

endmodule

// ===== design/maaf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Admission filter port checker
// Watches the top-level ports for response consistency and pacing.
// ----------------------------------------------------------------------------
module maaf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_verdict,
   input logic        rsp_relay,
   input logic [7:0]  rsp_relay_hops,
   input logic        rsp_rate_limited
);
   import maaf_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict)
         && $stable(rsp_relay) && $stable(rsp_relay_hops))
      else $error("stalled response beat changed");

   // relayed frames are accepted, not limited, and carry a raised hop count
   a_relay_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_relay |-> rsp_verdict == VERDICT_ACCEPT
         && !rsp_rate_limited && rsp_relay_hops != 8'd0)
      else $error("relay on a frame that was not cleanly accepted");

   // no relay means no hop count, and limiting only hits accepted frames
   a_no_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_relay |-> rsp_relay_hops == 8'd0
         && (!rsp_rate_limited || rsp_verdict == VERDICT_ACCEPT))
      else $error("hop count or rate limit without a relay decision");

   // each request beat occupies the block for a decide step
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on back-to-back cycles");

endmodule

bind mesh_alert_admission_filter maaf_checker u_maaf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_verdict      (rsp_verdict),
   .rsp_relay        (rsp_relay),
   .rsp_relay_hops   (rsp_relay_hops),
   .rsp_rate_limited (rsp_rate_limited)
);

// ===== verif/tb_mesh_alert_admission_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh alert admission filter testbench
// Drives frame headers with bursty traffic against a receiver that stalls in
// changing patterns, predicts each verdict and relay decision in a tracker
// class, and compares every response beat field by field in order.
// ----------------------------------------------------------------------------
module tb_mesh_alert_admission_filter;
   import maaf_pkg::*;

   // One frame header plus the time it was seen
   typedef struct {
      logic [7:0]  frame_length;
      logic [63:0] nonce;
      logic [63:0] sender_id;
      logic [31:0] sent_seconds;
      logic [7:0]  urgency;
      logic [7:0]  hops;
      logic [31:0] now_ms;
   } frame_type;

   // Register file contents as the filter sees them
   typedef struct {
      logic [7:0]  min_len;
      logic [7:0]  urgency_floor;
      logic        mute_on;
      logic [31:0] mute_until_ms;
      logic [63:0] own_id;
      logic        relay_on;
      logic [7:0]  hop_limit;
      logic [7:0]  relay_budget;
   } filter_cfg_type;

   // One response beat
   typedef struct {
      verdict_type verdict;
      logic        relay;
      logic [7:0]  relay_hops;
      logic        rate_limited;
   } verdict_beat_type;

   typedef enum {STALL_NONE, STALL_COIN, STALL_LONG, STALL_RARE} stall_mode_type;

   // -------------------------------------------------------------------------
   // Verdict tracker: mirrors registers, nonce history and the relay window,
   // and keeps the verdicts still owed by the block in arrival order.
   // -------------------------------------------------------------------------
   class admission_tracker;
      filter_cfg_type   cfg;
      logic [63:0]      nonce_hist [NONCE_DEPTH];
      int unsigned      hist_slot;
      logic [31:0]      window_open_ms;
      logic [7:0]       window_relays;
      verdict_beat_type due_verdicts [$];
      int unsigned      errors;
      int unsigned      frames_seen;
      int unsigned      beats_checked;
      int unsigned      relays;
      int unsigned      throttled;
      int unsigned      verdict_tally [7];

      function new();
         cfg = '{8'd16, 8'd0, 1'b0, 32'd0, 64'd0, 1'b1, 8'd3, 8'd10};
         foreach (nonce_hist[i]) nonce_hist[i] = '0;
         foreach (verdict_tally[i]) verdict_tally[i] = 0;
         hist_slot = 0;
         window_open_ms = '0;
         window_relays = '0;
         errors = 0;
         frames_seen = 0;
         beats_checked = 0;
         relays = 0;
         throttled = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [63:0] value);
         case (idx)
            CSR_MIN_FRAME_LEN:  cfg.min_len = value[7:0];
            CSR_URGENCY_MIN:    cfg.urgency_floor = value[7:0];
            CSR_MUTE_ACTIVE:    cfg.mute_on = value[0];
            CSR_MUTE_UNTIL_MS:  cfg.mute_until_ms = value[31:0];
            CSR_OWN_SESSION_ID: cfg.own_id = value;
            CSR_RELAY_ENABLED:  cfg.relay_on = value[0];
            CSR_MAX_HOPS:       cfg.hop_limit = value[7:0];
            CSR_RELAY_LIMIT:    cfg.relay_budget = value[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned due_count();
         return due_verdicts.size();
      endfunction

      // Work out the verdict for an accepted frame and advance the state
      function void take_frame(frame_type f);
         verdict_beat_type want;
         logic [31:0]      now_sec;
         logic [31:0]      age_sec;
         logic [31:0]      elapsed_ms;
         logic             replay;
         now_sec = f.now_ms / 32'd1000;
         want = '{VERDICT_SHORT, 1'b0, 8'd0, 1'b0};
         replay = 1'b0;
         if (f.frame_length < cfg.min_len) begin
            want.verdict = VERDICT_SHORT;
         end else begin
            foreach (nonce_hist[i]) if (nonce_hist[i] == f.nonce) replay = 1'b1;
            if (replay) begin
               want.verdict = VERDICT_DUP;
            end else begin
               // record the nonce even if a later check rejects the frame
               nonce_hist[hist_slot] = f.nonce;
               hist_slot = (hist_slot + 1) % NONCE_DEPTH;
               age_sec = now_sec - f.sent_seconds;
               if (f.sent_seconds > now_sec + FUTURE_SLACK_S || age_sec > MAX_AGE_S)
                  want.verdict = VERDICT_STALE;
               else if (f.urgency < cfg.urgency_floor)
                  want.verdict = VERDICT_URGENCY;
               else if (cfg.mute_on && f.now_ms < cfg.mute_until_ms)
                  want.verdict = VERDICT_MUTED;
               else if (f.sender_id == cfg.own_id)
                  want.verdict = VERDICT_OWN;
               else
                  want.verdict = VERDICT_ACCEPT;
            end
         end
         if (want.verdict == VERDICT_ACCEPT && cfg.relay_on && f.hops < cfg.hop_limit) begin
            elapsed_ms = f.now_ms - window_open_ms;
            if (elapsed_ms > WINDOW_MS) begin
               window_open_ms = f.now_ms;
               window_relays = '0;
            end
            if (window_relays >= cfg.relay_budget) begin
               want.rate_limited = 1'b1;
               throttled++;
            end else begin
               want.relay = 1'b1;
               want.relay_hops = f.hops + 8'd1;
               window_relays = window_relays + 8'd1;
               relays++;
            end
         end
         verdict_tally[int'(want.verdict)]++;
         frames_seen++;
         due_verdicts.push_back(want);
      endfunction

      function void match_verdict(verdict_beat_type got);
         verdict_beat_type want;
         if (due_verdicts.size() == 0) begin
            errors++;
            $display("[%0t] response beat with no frame outstanding: verdict %0d", $time,
                     got.verdict);
            return;
         end
         want = due_verdicts.pop_front();
         beats_checked++;
         if (got.verdict !== want.verdict || got.relay !== want.relay ||
             got.relay_hops !== want.relay_hops || got.rate_limited !== want.rate_limited)
         begin
            errors++;
            $display({"[%0t] beat %0d: expected verdict %0d relay %0b hops %0d limited %0b,",
                      " got verdict %0d relay %0b hops %0d limited %0b"},
                     $time, beats_checked, want.verdict, want.relay, want.relay_hops,
                     want.rate_limited, got.verdict, got.relay, got.relay_hops,
                     got.rate_limited);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals; every block input starts at a known value
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_frame_length = '0;
   logic [63:0] req_nonce        = '0;
   logic [63:0] req_sender_id    = '0;
   logic [31:0] req_sent_seconds = '0;
   logic [7:0]  req_urgency      = '0;
   logic [7:0]  req_hops         = '0;
   logic [31:0] req_now_ms       = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [2:0]  rsp_verdict;
   logic        rsp_relay;
   logic [7:0]  rsp_relay_hops;
   logic        rsp_rate_limited;
   logic        csr_write        = 1'b0;
   logic [2:0]  csr_index        = '0;
   logic [63:0] csr_data         = '0;

   admission_tracker tracker = new();

   // Nonces handed out recently; replays draw from here, some of them old
   // enough to have left the block's history
   logic [63:0] recent_nonces [$];

   mesh_alert_admission_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_length (req_frame_length),
      .req_nonce        (req_nonce),
      .req_sender_id    (req_sender_id),
      .req_sent_seconds (req_sent_seconds),
      .req_urgency      (req_urgency),
      .req_hops         (req_hops),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict      (rsp_verdict),
      .rsp_relay        (rsp_relay),
      .rsp_relay_hops   (rsp_relay_hops),
      .rsp_rate_limited (rsp_rate_limited),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: pick a new random stall pattern periodically so stalls land
   // on both steps of the block's work, with calm stretches in between
   int unsigned    stall_cycle = 0;
   stall_mode_type stall_mode  = STALL_NONE;

   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 300 == 0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_COIN: rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_LONG: rsp_stall <= (stall_cycle % 8) < 6;
         default:    rsp_stall <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Response monitor: check each beat taken at this edge
   always @(posedge clock) begin
      verdict_beat_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.verdict      = verdict_type'(rsp_verdict);
         got.relay        = rsp_relay;
         got.relay_hops   = rsp_relay_hops;
         got.rate_limited = rsp_rate_limited;
         tracker.match_verdict(got);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Present one beat and hold it until the block takes it
   task automatic drive_frame(input frame_type f);
      req_valid        <= 1'b1;
      req_frame_length <= f.frame_length;
      req_nonce        <= f.nonce;
      req_sender_id    <= f.sender_id;
      req_sent_seconds <= f.sent_seconds;
      req_urgency      <= f.urgency;
      req_hops         <= f.hops;
      req_now_ms       <= f.now_ms;
      do @(posedge clock); while (req_stall);
      tracker.take_frame(f);
   endtask

   // Send a list in bursts; drop valid only when a real gap follows or the list
   // ends, so it is never lowered and raised in the same step
   task automatic push_frames(input frame_type frames [$]);
      int unsigned idx;
      int unsigned burst;
      int unsigned gap;
      idx = 0;
      while (idx < frames.size()) begin
         burst = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 80) : $urandom_range(1, 6);
         for (int k = 0; k < burst && idx < frames.size(); k++) begin
            drive_frame(frames[idx]);
            idx++;
         end
         gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
         if (gap > 0 || idx == frames.size()) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      tracker.write_reg(idx, value);
   endtask

   // Write every register; junk in the unused upper bits must be ignored
   task automatic program_filter(input filter_cfg_type s);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_reg(CSR_MIN_FRAME_LEN,  {junk[63:8], s.min_len});
      write_reg(CSR_URGENCY_MIN,    {junk[55:0], s.urgency_floor});
      write_reg(CSR_MUTE_ACTIVE,    {junk[62:0], s.mute_on});
      write_reg(CSR_MUTE_UNTIL_MS,  {junk[31:0], s.mute_until_ms});
      write_reg(CSR_OWN_SESSION_ID, s.own_id);
      write_reg(CSR_RELAY_ENABLED,  {junk[63:1], s.relay_on});
      write_reg(CSR_MAX_HOPS,       {junk[47:0], s.hop_limit, junk[7:0]} >> 8);
      write_reg(CSR_RELAY_LIMIT,    {junk[59:4], s.relay_budget});
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      while (tracker.due_count() != 0) @(posedge clock);
   endtask

   function automatic filter_cfg_type make_cfg(logic [7:0] min_len, logic [7:0] urgency_floor,
                                               logic mute_on, logic [31:0] mute_until_ms,
                                               logic [63:0] own_id, logic relay_on,
                                               logic [7:0] hop_limit,
                                               logic [7:0] relay_budget);
      filter_cfg_type s;
      s = '{min_len, urgency_floor, mute_on, mute_until_ms, own_id, relay_on, hop_limit,
            relay_budget};
      return s;
   endfunction

   function automatic frame_type pack_frame(logic [7:0] len, logic [63:0] nonce,
                                            logic [63:0] sender, logic [31:0] sent,
                                            logic [7:0] urgency, logic [7:0] hops,
                                            logic [31:0] now_ms);
      frame_type f;
      f = '{len, nonce, sender, sent, urgency, hops, now_ms};
      return f;
   endfunction

   // -------------------------------------------------------------------------
   // Directed frames: length limits, zero nonce after reset, replay, both
   // freshness edges, urgency floor, mute edge, own origin, relay budget,
   // window edge and restart, and time wrap at the top of the range.
   // -------------------------------------------------------------------------
   localparam logic [31:0] T_MS   = 32'd100_000_000;
   localparam logic [31:0] T_SEC  = 32'd100_000;
   localparam logic [63:0] OWN_ID = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] PEER   = 64'h0000_0000_0000_0005;

   task automatic run_directed();
      frame_type frames [$];
      // budget of two relays per window, mute ends at T_MS
      program_filter(make_cfg(8'd16, 8'd4, 1'b1, T_MS, OWN_ID, 1'b1, 8'd3, 8'd2));
      frames.push_back(pack_frame(8'd0,   64'd1,  PEER, T_SEC,        8'd9,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd15,  64'd2,  PEER, T_SEC,        8'd9,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd255, 64'd0,  PEER, T_SEC,        8'd9,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd10, PEER, T_SEC,        8'd4,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd10, PEER, T_SEC,        8'd4,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd11, PEER, T_SEC + 30,   8'd255, 8'd2, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd12, PEER, T_SEC,        8'd9,   8'd0,
                                  T_MS + 1000));
      frames.push_back(pack_frame(8'd16,  64'd13, PEER, T_SEC + 31,   8'd9,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd14, PEER, T_SEC - 300,  8'd9,   8'd3, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd15, PEER, T_SEC - 301,  8'd9,   8'd0, T_MS));
      // a stale frame still leaves its nonce behind
      frames.push_back(pack_frame(8'd16,  64'd13, PEER, T_SEC,        8'd9,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd16, PEER, T_SEC,        8'd3,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd17, PEER, T_SEC,        8'd4,   8'd0,
                                  T_MS - 1));
      frames.push_back(pack_frame(8'd16,  64'd18, OWN_ID, T_SEC,      8'd9,   8'd0, T_MS));
      frames.push_back(pack_frame(8'd16,  '1,     '1,   T_SEC,        8'd255, 8'd255, T_MS));
      frames.push_back(pack_frame(8'd16,  64'd19, PEER, T_SEC + 59,   8'd9,   8'd1,
                                  T_MS + 60000));
      frames.push_back(pack_frame(8'd16,  64'd20, PEER, T_SEC + 60,   8'd9,   8'd1,
                                  T_MS + 60001));
      frames.push_back(pack_frame(8'd16,  64'd21, PEER, 32'd4294967,  8'd9,   8'd0, '1));
      frames.push_back(pack_frame(8'd16,  64'd22, PEER, 32'd0,        8'd9,   8'd0, 32'd0));
      frames.push_back(pack_frame(8'd16,  64'd23, PEER, '1,           8'd9,   8'd0, 32'd0));
      frames.push_back(pack_frame(8'd16,  64'd24, PEER, 32'd30,       8'd9,   8'd0, 32'd0));
      frames.push_back(pack_frame(8'd255, 64'd25, PEER, '1,           8'd255, 8'd0, '1));
      push_frames(frames);
   endtask

   // -------------------------------------------------------------------------
   // Random phase: mostly plausible traffic on a slowly advancing clock with
   // random content, mixed with replays, zero nonces, short frames, skewed
   // timestamps, low urgency, own-origin frames and the odd clock jump
   // -------------------------------------------------------------------------
   task automatic run_phase(input filter_cfg_type s, input logic [31:0] start_ms,
                            input int unsigned count);
      frame_type   frames [$];
      frame_type   f;
      logic [31:0] clock_ms;
      logic [31:0] now_sec;
      int unsigned roll;
      wait_drained();
      program_filter(s);
      clock_ms = start_ms;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(0, 2500);
         now_sec = clock_ms / 32'd1000;
         f.now_ms = clock_ms;

         roll = $urandom_range(0, 99);
         if (roll < 8) f.frame_length = 8'($urandom_range(0, 255));
         else f.frame_length = 8'($urandom_range(s.min_len, 255));

         roll = $urandom_range(0, 99);
         if (roll < 12 && recent_nonces.size() > 0)
            f.nonce = recent_nonces[$urandom_range(0, recent_nonces.size() - 1)];
         else if (roll < 14) f.nonce = '0;
         else f.nonce = {$urandom, $urandom};
         recent_nonces.push_back(f.nonce);
         if (recent_nonces.size() > 48) void'(recent_nonces.pop_front());

         roll = $urandom_range(0, 99);
         if (roll < 8) f.sent_seconds = $urandom;
         else if (roll < 15) f.sent_seconds = now_sec + $urandom_range(25, 40);
         else if (roll < 22) f.sent_seconds = now_sec - $urandom_range(290, 310);
         else f.sent_seconds = now_sec - $urandom_range(0, 60);

         roll = $urandom_range(0, 99);
         if (roll < 15) f.urgency = 8'($urandom_range(0, 255));
         else f.urgency = 8'($urandom_range(s.urgency_floor, 255));

         f.sender_id = ($urandom_range(0, 99) < 8) ? s.own_id : {$urandom, $urandom};

         roll = $urandom_range(0, 99);
         if (roll < 6) f.hops = 8'($urandom_range(0, 255));
         else f.hops = 8'($urandom_range(0, int'(s.hop_limit) + 1));

         frames.push_back(f);
      end
      push_frames(frames);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0] base_ms;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // reset-like settings with a full relay budget in play
      run_phase(make_cfg(8'd16, 8'd0, 1'b0, 32'd0, {$urandom, $urandom}, 1'b1, 8'd3,
                         8'd10), $urandom, 250);
      // every length passes, only top urgency passes, widest hop and budget limits
      run_phase(make_cfg(8'd0, 8'd255, 1'b0, 32'd0, {$urandom, $urandom}, 1'b1, 8'd255,
                         8'd255), $urandom, 250);
      // longest frames only, mute for the first part, no relay at all
      base_ms = $urandom;
      run_phase(make_cfg(8'd255, 8'd0, 1'b1, base_ms + 32'd150000, 64'd0, 1'b1, 8'd0,
                         8'd0), base_ms, 250);
      // mute to the end of time, relaying off
      run_phase(make_cfg(8'($urandom_range(0, 40)), 8'($urandom_range(0, 200)), 1'b1, '1,
                         {$urandom, $urandom}, 1'b0, 8'd3, 8'd10), $urandom, 250);
      // zero budget: every wanted relay is held back
      run_phase(make_cfg(8'd8, 8'd0, 1'b0, 32'd0, {$urandom, $urandom}, 1'b1, 8'd8, 8'd0),
                $urandom, 250);
      // mute requested but already over
      run_phase(make_cfg(8'd16, 8'd10, 1'b1, 32'd0, {$urandom, $urandom}, 1'b1, 8'd5,
                         8'd1), $urandom, 250);
      // all-ones own id, clock wraps through zero
      run_phase(make_cfg(8'd16, 8'd0, 1'b0, 32'd0, '1, 1'b1, 8'd4, 8'd3), 32'hFFFE_0000,
                250);
      // everything random
      base_ms = $urandom;
      run_phase(make_cfg(8'($urandom_range(0, 40)), 8'($urandom_range(0, 200)),
                         1'($urandom_range(0, 1)), base_ms + $urandom_range(0, 400000),
                         {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 20))),
                base_ms, 250);

      wait_drained();
      // allow a stray beat to surface before judging
      repeat (10) @(posedge clock);

      $display({"Ran %0d frames over 9 register settings: %0d accepted, %0d relayed,",
                " %0d held by the window budget"},
               tracker.frames_seen, tracker.verdict_tally[int'(VERDICT_ACCEPT)],
               tracker.relays, tracker.throttled);
      $display({"Rejections: %0d short, %0d replay, %0d stale/future, %0d urgency,",
                " %0d muted, %0d own"},
               tracker.verdict_tally[int'(VERDICT_SHORT)],
               tracker.verdict_tally[int'(VERDICT_DUP)],
               tracker.verdict_tally[int'(VERDICT_STALE)],
               tracker.verdict_tally[int'(VERDICT_URGENCY)],
               tracker.verdict_tally[int'(VERDICT_MUTED)],
               tracker.verdict_tally[int'(VERDICT_OWN)]);
      if (tracker.errors == 0 && tracker.due_count() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("Timed out with %0d responses outstanding", tracker.due_count());
      $display("Some tests failed");
      $finish;
   end

endmodule
